### rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 median filter
// Sizes, configuration register indexes, window and pipeline records, and
// the small compare helpers of the sorting network.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

    // Geometry and widths
    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = COL_W + 1;        // holds a width up to MAX_WIDTH
    localparam int LAG_W      = COL_W + 1;        // counts up to width + 1
    localparam int ROWS_MAX   = 4096;
    localparam int ROW_W      = 12;
    localparam int RWS_W      = 13;               // holds a row count up to ROWS_MAX

    // Configuration register file
    localparam int LW_W       = 11;
    localparam int FR_W       = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [LW_W-1:0] LW_RESET = 11'd640;
    localparam logic [FR_W-1:0] FR_RESET = 13'd480;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int PEND_W     = FIFO_AW + 1;

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef logic [COL_W-1:0]      t_col;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH = 1'b0,
        CFG_FRAME_ROWS = 1'b1
    } t_cfg_idx;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        logic emit;
        logic border;
        logic last;
    } t_meta;

    // One sorted triple
    typedef struct packed {
        t_pix lo;
        t_pix md;
        t_pix hi;
    } t_trip;

    // One result entry
    typedef struct packed {
        t_pix pix;
        logic last;
    } t_res;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_trip sort3(input t_pix a, input t_pix b, input t_pix c);
        t_trip t;
        t.lo = min2(min2(a, b), c);
        t.hi = max2(max2(a, b), c);
        t.md = med3(a, b, c);
        return t;
    endfunction

endpackage

`default_nettype wire

### rtl/mf3_stream_if.sv
// ----------------------------------------------------------------------------
// mf3_stream_if: pixel stream channels of the 3x3 median filter
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface mf3_pix_in_if import mf3_pkg::*; ();
    logic valid;
    logic ready;
    t_pix pixel_in;
    logic flush;

    modport source (output valid, output pixel_in, output flush, input ready);
    modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

interface mf3_pix_out_if import mf3_pkg::*; ();
    logic valid;
    logic ready;
    t_pix pixel_out;
    logic frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

### rtl/median_3x3_filter_unit.sv
// ----------------------------------------------------------------------------
// median_3x3_filter_unit: streaming 3x3 median filter, top level
// Position counters, configuration registers, acceptance control, and the
// line store, median pipeline and result queue.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                       Transfer
// i_pix     in   pixel_in[7:0], flush          valid && ready
// o_pix     out  pixel_out[7:0], frame_last    valid && ready
// i_cfg_*   in   index[0], data[12:0]          i_cfg_we
//
// One pixel per clock sustained while i_pix.ready is high.
// Results lag the input stream by line_width + 1 items (flush items drain).
// The line memories are read at acceptance and the upper line written back
// the next cycle; a hit on that entry is forwarded.
// Reset is synchronous; the line memories are not cleared.
// i_pix.ready drops only when 8 results are queued or in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module median_3x3_filter_unit import mf3_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    mf3_pix_in_if.sink             i_pix,
    mf3_pix_out_if.source          o_pix,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [LW_W-1:0]   r_line_width;
    logic [FR_W-1:0]   r_frame_rows;

    t_col              r_in_col;
    t_col              r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [LAG_W-1:0]  r_lag;
    logic [PEND_W-1:0] r_pending;

    t_col              n_in_col;
    t_col              n_out_col;
    logic [ROW_W-1:0]  n_out_row;
    logic [LAG_W-1:0]  n_lag;
    logic [PEND_W-1:0] n_pending;

    logic              r_s1_valid;
    t_col              r_s1_col;
    t_meta             r_s1_meta;
    t_pix              r_s1_pix;

    logic              acc;
    logic              pop;
    t_pix              pix_eff;
    logic [WID_W-1:0]  w_eff;
    logic [RWS_W-1:0]  r_eff;
    t_col              col_eff;
    t_col              oc;
    logic [ROW_W-1:0]  orow;
    logic [WID_W-1:0]  in_p1;
    logic [WID_W-1:0]  oc_p1;
    logic [RWS_W-1:0]  orow_p1;
    t_meta             meta;

    t_pix              ls_upper;
    t_pix              ls_middle;
    logic              med_valid;
    t_res              med_res;
    logic              q_valid;
    t_res              q_res;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LW_RESET;
            r_frame_rows <= FR_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data[LW_W-1:0];
                CFG_FRAME_ROWS: r_frame_rows <= i_cfg_data[FR_W-1:0];
                default:        ;
            endcase
        end
    end

    // Handshakes
    assign i_pix.ready = (r_pending < PEND_W'(FIFO_DEPTH));
    assign acc         = i_pix.valid && i_pix.ready;
    assign pop         = q_valid && o_pix.ready;
    assign pix_eff     = i_pix.flush ? '0 : i_pix.pixel_in;

    // Clamp the frame geometry
    always_comb begin
        if (r_line_width == '0) begin
            w_eff = WID_W'(1);
        end else if (int'(r_line_width) > MAX_WIDTH) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(r_line_width);
        end
        if (r_frame_rows == '0) begin
            r_eff = RWS_W'(1);
        end else if (int'(r_frame_rows) > ROWS_MAX) begin
            r_eff = RWS_W'(ROWS_MAX);
        end else begin
            r_eff = RWS_W'(r_frame_rows);
        end
    end

    // Positions of this item and of the result it releases
    always_comb begin
        col_eff = ({1'b0, r_in_col} >= w_eff) ? '0 : r_in_col;
        oc      = ({1'b0, r_out_col} >= w_eff) ? '0 : r_out_col;
        orow    = ({1'b0, r_out_row} >= r_eff) ? ROW_W'(r_eff - 1'b1) : r_out_row;
        in_p1   = {1'b0, col_eff} + 1'b1;
        oc_p1   = {1'b0, oc} + 1'b1;
        orow_p1 = {1'b0, orow} + 1'b1;

        meta.emit   = (r_lag >= LAG_W'(w_eff + 1'b1));
        meta.border = (orow == '0) || (orow_p1 >= r_eff) || (oc == '0) || (oc_p1 >= w_eff);
        meta.last   = (orow_p1 >= r_eff) && (oc_p1 >= w_eff);
    end

    // Counter next values
    always_comb begin
        n_in_col  = (in_p1 >= w_eff) ? '0 : in_p1[COL_W-1:0];
        n_out_col = oc;
        n_out_row = orow;
        n_lag     = r_lag;
        if (!meta.emit) begin
            n_lag = r_lag + 1'b1;
        end else if (meta.last) begin
            n_in_col  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_lag     = '0;
        end else if (oc_p1 >= w_eff) begin
            n_out_col = '0;
            n_out_row = orow + 1'b1;
        end else begin
            n_out_col = oc_p1[COL_W-1:0];
        end
    end

    // Results queued or in flight
    always_comb begin
        n_pending = r_pending;
        if ((acc && meta.emit) && !pop) begin
            n_pending = r_pending + 1'b1;
        end else if (!(acc && meta.emit) && pop) begin
            n_pending = r_pending - 1'b1;
        end
    end

    // Advance counters on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_lag      <= '0;
            r_pending  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_in_col  <= n_in_col;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
                r_lag     <= n_lag;
            end
            r_pending  <= n_pending;
            r_s1_valid <= acc;
        end
    end

    // Hold the item while the line memories are read
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_col  <= col_eff;
            r_s1_meta <= meta;
            r_s1_pix  <= pix_eff;
        end
    end

    mf3_line_store u_line_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (acc),
        .i_rd_col (col_eff),
        .i_pix    (pix_eff),
        .i_wb_en  (r_s1_valid),
        .i_wb_col (r_s1_col),
        .o_upper  (ls_upper),
        .o_middle (ls_middle)
    );

    mf3_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_meta   (r_s1_meta),
        .i_upper  (ls_upper),
        .i_middle (ls_middle),
        .i_pix    (r_s1_pix),
        .o_valid  (med_valid),
        .o_res    (med_res)
    );

    mf3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (med_valid),
        .i_res   (med_res),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_res   (q_res)
    );

    assign o_pix.valid      = q_valid;
    assign o_pix.pixel_out  = q_res.pix;
    assign o_pix.frame_last = q_res.last;

`ifndef SYNTHESIS
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(FIFO_DEPTH))
        else $error("pending result count exceeds queue depth");

    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (r_pending != '0))
        else $error("result offered without a reserved slot");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && meta.emit && meta.last) |=>
            (r_in_col == '0 && r_out_col == '0 && r_out_row == '0 && r_lag == '0))
        else $error("counters not cleared after the last pixel of a frame");

    a_no_result_in_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !meta.emit) |=> (r_lag == $past(r_lag) + 1'b1))
        else $error("lag count did not advance on a non-emitting item");
`endif

endmodule

`default_nettype wire

### rtl/mf3_line_store.sv
// ----------------------------------------------------------------------------
// mf3_line_store: upper and middle line memories
// Both memories are read at the column of an accepted pixel. The middle line
// takes the new pixel in the same cycle; the upper line takes the old middle
// value in the cycle after, with forwarding when a read in that cycle hits it.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_line_store import mf3_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_rd_en,
    input  t_col i_rd_col,
    input  t_pix i_pix,
    input  wire  i_wb_en,
    input  t_col i_wb_col,
    output t_pix o_upper,
    output t_pix o_middle
);

    t_pix r_up_mem  [MAX_WIDTH];
    t_pix r_mid_mem [MAX_WIDTH];
    t_pix r_up_q;
    t_pix r_mid_q;
    logic r_fwd;
    t_pix r_fwd_data;

    // Middle line: read old value, write new pixel
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mid_q               <= r_mid_mem[i_rd_col];
            r_mid_mem[i_rd_col]   <= i_pix;
        end
    end

    // Upper line: read at accept, write back the old middle value next cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_q <= r_up_mem[i_rd_col];
        end
        if (i_wb_en) begin
            r_up_mem[i_wb_col] <= r_mid_q;
        end
    end

    // Forward the write-back when a read hits the entry being written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wb_en && (i_wb_col == i_rd_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= r_mid_q;
        end
    end

    assign o_upper  = r_fwd ? r_fwd_data : r_up_q;
    assign o_middle = r_mid_q;

endmodule

`default_nettype wire

### rtl/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median: 3x3 window and pipelined median network
// The window shifts one column per item. Three stages follow: sort each row,
// combine mins/medians/maxes, take the final median or the border pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_median import mf3_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    input  t_meta i_meta,
    input  t_pix  i_upper,
    input  t_pix  i_middle,
    input  t_pix  i_pix,
    output logic  o_valid,
    output t_res  o_res
);

    t_pix  r_win [3][3];
    logic  r_w_valid;
    t_meta r_w_meta;

    logic  r_a_valid;
    t_meta r_a_meta;
    t_pix  r_a_centre;
    t_trip r_a_trip [3];

    logic  r_b_valid;
    t_meta r_b_meta;
    t_pix  r_b_centre;
    t_pix  r_b_lo;
    t_pix  r_b_md;
    t_pix  r_b_hi;

    logic  r_c_valid;
    t_res  r_c_res;

    // Shift the window left and load the new column on the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (i_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= i_upper;
            r_win[1][2] <= i_middle;
            r_win[2][2] <= i_pix;
        end
    end

    // Valid flags of the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_w_valid <= i_valid;
            r_a_valid <= r_w_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid && r_b_meta.emit;
        end
    end

    // Payload of the stages
    always_ff @(posedge i_clk) begin
        r_w_meta <= i_meta;

        // sort each row
        r_a_meta   <= r_w_meta;
        r_a_centre <= r_win[1][1];
        for (int k = 0; k < 3; k++) begin
            r_a_trip[k] <= sort3(r_win[k][0], r_win[k][1], r_win[k][2]);
        end

        // max of mins, median of medians, min of maxes
        r_b_meta   <= r_a_meta;
        r_b_centre <= r_a_centre;
        r_b_lo     <= max2(max2(r_a_trip[0].lo, r_a_trip[1].lo), r_a_trip[2].lo);
        r_b_md     <= med3(r_a_trip[0].md, r_a_trip[1].md, r_a_trip[2].md);
        r_b_hi     <= min2(min2(r_a_trip[0].hi, r_a_trip[1].hi), r_a_trip[2].hi);

        // final pick: border pixels pass through
        r_c_res.pix  <= r_b_meta.border ? r_b_centre : med3(r_b_lo, r_b_md, r_b_hi);
        r_c_res.last <= r_b_meta.last;
    end

    assign o_valid = r_c_valid;
    assign o_res   = r_c_res;

endmodule

`default_nettype wire

### rtl/mf3_out_fifo.sv
// ----------------------------------------------------------------------------
// mf3_out_fifo: result queue
// Small register queue that decouples the pipeline from output stalls.
// Space is reserved at input acceptance, so a push never meets a full queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_out_fifo import mf3_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_res i_res,
    input  wire  i_pop,
    output logic o_valid,
    output t_res o_res
);

    t_res                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr;
    logic [FIFO_AW-1:0]  r_rd;
    logic [PEND_W-1:0]   r_cnt;
    logic [PEND_W-1:0]   n_cnt;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    // Occupancy next value
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];

endmodule

`default_nettype wire
